>>> rtl/core/npps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npps_pkg: shared types and constants of the priority scheduler
// Field widths, default batch depth and the stored job record.
// ----------------------------------------------------------------------------
package npps_pkg;

	localparam int unsigned ID_W         = 8;
	localparam int unsigned ARR_W        = 16;
	localparam int unsigned BURST_W      = 16;
	localparam int unsigned URG_W        = 8;
	localparam int unsigned COMPL_W      = 22;
	localparam int unsigned SPAN_W       = 21;
	localparam int unsigned MAX_JOBS_DEF = 32;

	typedef struct packed {
		logic [ID_W-1:0]    job_id;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [URG_W-1:0]   urgency;
	} job_rec_t;

endpackage : npps_pkg
`default_nettype wire

>>> rtl/core/npps_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npps_ifs: job and result channels of the priority scheduler
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface npps_job_if;
	import npps_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    job_id;
	logic [ARR_W-1:0]   arrival;
	logic [BURST_W-1:0] burst;
	logic [URG_W-1:0]   urgency;
	logic               final_job;

	modport source (output valid, output job_id, output arrival, output burst,
		output urgency, output final_job, input ready);
	modport sink (input valid, input job_id, input arrival, input burst,
		input urgency, input final_job, output ready);
endinterface : npps_job_if

interface npps_res_if;
	import npps_pkg::*;

	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    out_job_id;
	logic [ARR_W-1:0]   out_arrival;
	logic [BURST_W-1:0] out_burst;
	logic [URG_W-1:0]   out_urgency;
	logic [COMPL_W-1:0] completion;
	logic [SPAN_W-1:0]  turnaround;
	logic [SPAN_W-1:0]  waiting;
	logic               final_result;

	modport source (output valid, output out_job_id, output out_arrival,
		output out_burst, output out_urgency, output completion,
		output turnaround, output waiting, output final_result, input ready);
	modport sink (input valid, input out_job_id, input out_arrival,
		input out_burst, input out_urgency, input completion,
		input turnaround, input waiting, input final_result, output ready);
endinterface : npps_res_if
`default_nettype wire

>>> rtl/core/nonpreemptive_priority_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_unit: batch non-preemptive priority scheduler
// Collects a batch of jobs, keeps it sorted by (arrival, urgency), schedules it
// with one shared compare unit scanning the job memory, then streams results.
// ----------------------------------------------------------------------------
// Load: each job transfer is inserted in sorted position; walking down from the
//   top, each stored entry that is strictly later is read, compared and shifted
//   up one slot, and the new job is written into the slot left free.
// Schedule: each decision is one scan of the job memory; at most 2n decisions
//   (n job starts plus at most n jumps over idle gaps).
// Emit: one result at a time, held in output registers until the sink takes it.
// The job memory has a single read port, one entry per cycle.
// Reset: idle, batch empty, finished flags clear; memories are not cleared.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_unit #(
	parameter int unsigned MAX_JOBS = npps_pkg::MAX_JOBS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	npps_job_if.sink   job,
	npps_res_if.source result
);
	import npps_pkg::*;

	localparam int unsigned IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned CNT_W   = $clog2(MAX_JOBS + 1);
	// Worst finish time is (MAX_JOBS + 1) * max burst, so this never wraps.
	localparam int unsigned RAW_T_W = BURST_W + 1 + $clog2(MAX_JOBS);
	localparam int unsigned TIME_W  = (RAW_T_W > COMPL_W) ? RAW_T_W : COMPL_W;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_INS_RD    = 4'd1;
	localparam logic [3:0] ST_INS_CMP   = 4'd2;
	localparam logic [3:0] ST_SC_START  = 4'd3;
	localparam logic [3:0] ST_SC_SCAN   = 4'd4;
	localparam logic [3:0] ST_SC_DRAIN  = 4'd5;
	localparam logic [3:0] ST_SC_DECIDE = 4'd6;
	localparam logic [3:0] ST_EM_RD     = 4'd7;
	localparam logic [3:0] ST_EM_LD     = 4'd8;
	localparam logic [3:0] ST_EM_WAIT   = 4'd9;

	// Control state
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    job_cnt_q;
	logic [CNT_W-1:0]    pos_q;
	logic                last_q;
	logic [IDX_W-1:0]    scan_i_q;
	logic                valid_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [CNT_W-1:0]    done_q;
	logic [MAX_JOBS-1:0] fin_q;
	logic [TIME_W-1:0]   clock_q;
	logic [IDX_W-1:0]    emit_k_q;
	logic                out_valid_q;
	logic                found_q;
	logic                have_next_q;

	// Data path registers
	job_rec_t            new_q;
	logic [IDX_W-1:0]    pick_q;
	logic [URG_W-1:0]    pick_urg_q;
	logic [BURST_W-1:0]  pick_burst_q;
	logic [ARR_W-1:0]    next_arr_q;
	job_rec_t            out_rec_q;
	logic [COMPL_W-1:0]  out_compl_q;
	logic [SPAN_W-1:0]   out_tat_q;
	logic [SPAN_W-1:0]   out_wait_q;
	logic                out_final_q;

	// Job memory and completion memory, one write and one registered read each
	job_rec_t            rec_mem [MAX_JOBS];
	logic [TIME_W-1:0]   cmp_mem [MAX_JOBS];
	job_rec_t            rd_rec_q;
	logic [TIME_W-1:0]   cmp_rd_q;

	logic                rec_we;
	logic [IDX_W-1:0]    rec_wa;
	job_rec_t            rec_wd;
	logic [IDX_W-1:0]    rd_addr;
	logic                cmp_we;
	logic [TIME_W-1:0]   cmp_wd;

	logic                job_xfer;
	logic                res_xfer;
	logic                later;
	logic [IDX_W-1:0]    last_idx;
	logic [CNT_W-1:0]    done_nx;
	logic                ev_open;
	logic                ev_ready;
	logic                take_pick;
	logic                take_next;
	logic [TIME_W-1:0]   tat_full;
	logic [TIME_W-1:0]   wait_full;

	assign job_xfer = job.valid && job.ready;
	assign res_xfer = result.valid && result.ready;
	assign last_idx = IDX_W'(job_cnt_q - CNT_W'(1));
	assign done_nx  = done_q + CNT_W'(1);

	// Insertion compare: the stored entry moves up only when strictly later,
	// which keeps equal keys in arrival order of the transfers.
	assign later = {rd_rec_q.arrival, rd_rec_q.urgency} > {new_q.arrival, new_q.urgency};

	// Shared compare unit of the scan: one memory entry per cycle
	assign ev_open   = valid_s1 && !fin_q[idx_s1];
	assign ev_ready  = TIME_W'(rd_rec_q.arrival) <= clock_q;
	assign take_pick = ev_open && ev_ready &&
		(!found_q || (rd_rec_q.urgency < pick_urg_q));
	assign take_next = ev_open && !ev_ready &&
		(!have_next_q || (rd_rec_q.arrival < next_arr_q));

	assign cmp_we = (state_q == ST_SC_DECIDE) && found_q;
	assign cmp_wd = clock_q + TIME_W'(pick_burst_q);

	assign tat_full  = cmp_rd_q - TIME_W'(rd_rec_q.arrival);
	assign wait_full = tat_full - TIME_W'(rd_rec_q.burst);

	// Memory port steering
	always_comb begin
		rd_addr = '0;
		rec_we  = 1'b0;
		rec_wa  = pos_q[IDX_W-1:0];
		rec_wd  = new_q;
		unique case (state_q)
			ST_INS_RD: begin
				if (pos_q == '0) begin
					rec_we = 1'b1;
				end else begin
					rd_addr = IDX_W'(pos_q - CNT_W'(1));
				end
			end
			ST_INS_CMP: begin
				rec_we = 1'b1;
				if (later) begin
					rec_wd = rd_rec_q;
				end
			end
			ST_SC_SCAN: rd_addr = scan_i_q;
			ST_EM_RD:   rd_addr = emit_k_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		rd_rec_q <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmp_we) begin
			cmp_mem[pick_q] <= cmp_wd;
		end
		cmp_rd_q <= cmp_mem[rd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_cnt_q   <= '0;
			pos_q       <= '0;
			last_q      <= 1'b0;
			scan_i_q    <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			done_q      <= '0;
			fin_q       <= '0;
			clock_q     <= '0;
			emit_k_q    <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			have_next_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SC_SCAN);
			idx_s1   <= scan_i_q;
			if (take_pick) begin
				found_q <= 1'b1;
			end
			if (take_next) begin
				have_next_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (job_xfer) begin
						pos_q   <= job_cnt_q;
						// A full buffer closes the batch on its own.
						last_q  <= job.final_job ||
							(job_cnt_q == CNT_W'(MAX_JOBS - 1));
						state_q <= ST_INS_RD;
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						job_cnt_q <= job_cnt_q + CNT_W'(1);
						state_q   <= last_q ? ST_SC_START : ST_IDLE;
						clock_q   <= '0;
						fin_q     <= '0;
						done_q    <= '0;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (later) begin
						// Shift the stored entry up one slot and keep walking down.
						pos_q   <= pos_q - CNT_W'(1);
						state_q <= ST_INS_RD;
					end else begin
						job_cnt_q <= job_cnt_q + CNT_W'(1);
						state_q   <= last_q ? ST_SC_START : ST_IDLE;
						clock_q   <= '0;
						fin_q     <= '0;
						done_q    <= '0;
					end
				end
				ST_SC_START: begin
					found_q     <= 1'b0;
					have_next_q <= 1'b0;
					scan_i_q    <= '0;
					state_q     <= ST_SC_SCAN;
				end
				ST_SC_SCAN: begin
					if (scan_i_q == last_idx) begin
						state_q <= ST_SC_DRAIN;
					end else begin
						scan_i_q <= scan_i_q + IDX_W'(1);
					end
				end
				ST_SC_DRAIN: begin
					state_q <= ST_SC_DECIDE;
				end
				ST_SC_DECIDE: begin
					if (found_q) begin
						// Run the picked job to completion.
						clock_q        <= cmp_wd;
						fin_q[pick_q]  <= 1'b1;
						done_q         <= done_nx;
						if (done_nx == job_cnt_q) begin
							emit_k_q <= '0;
							state_q  <= ST_EM_RD;
						end else begin
							state_q <= ST_SC_START;
						end
					end else begin
						// Nothing ready: advance time to the next arrival.
						clock_q <= TIME_W'(next_arr_q);
						state_q <= ST_SC_START;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EM_WAIT;
				end
				ST_EM_WAIT: begin
					if (res_xfer) begin
						out_valid_q <= 1'b0;
						if (emit_k_q == last_idx) begin
							job_cnt_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							emit_k_q <= emit_k_q + IDX_W'(1);
							state_q  <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && job_xfer) begin
			new_q.job_id  <= job.job_id;
			new_q.arrival <= job.arrival;
			new_q.burst   <= job.burst;
			new_q.urgency <= job.urgency;
		end
		if (take_pick) begin
			pick_q       <= idx_s1;
			pick_urg_q   <= rd_rec_q.urgency;
			pick_burst_q <= rd_rec_q.burst;
		end
		if (take_next) begin
			next_arr_q <= rd_rec_q.arrival;
		end
		if (state_q == ST_EM_LD) begin
			out_rec_q   <= rd_rec_q;
			out_compl_q <= cmp_rd_q[COMPL_W-1:0];
			out_tat_q   <= tat_full[SPAN_W-1:0];
			out_wait_q  <= wait_full[SPAN_W-1:0];
			out_final_q <= (emit_k_q == last_idx);
		end
	end

	assign job.ready           = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.out_job_id   = out_rec_q.job_id;
	assign result.out_arrival  = out_rec_q.arrival;
	assign result.out_burst    = out_rec_q.burst;
	assign result.out_urgency  = out_rec_q.urgency;
	assign result.completion   = out_compl_q;
	assign result.turnaround   = out_tat_q;
	assign result.waiting      = out_wait_q;
	assign result.final_result = out_final_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_cnt_q <= CNT_W'(MAX_JOBS))
		else $error("batch count beyond buffer depth");

	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fin_q) == int'(done_q))
		else $error("finished flags disagree with done count");

	a_pick_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_we |-> !fin_q[pick_q])
		else $error("scheduled a job that already finished");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && result.final_result) |=> (job.ready && !result.valid))
		else $error("block not idle after last result of batch");

endmodule : nonpreemptive_priority_scheduler_unit
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the non-preemptive priority scheduler
// Job batches go in over a valid/ready channel, with the sender pausing between bursts.
// A local model sorts and schedules each closed batch, and every result
// transfer is compared field by field with the oldest scheduled job.
// ----------------------------------------------------------------------------
module testbench;
	import npps_pkg::*;

	localparam int unsigned BATCH_DEPTH = MAX_JOBS_DEF;

	// One pending job together with its end-of-batch mark.
	typedef struct {
		job_rec_t job;
		logic     final_job;
	} job_item_t;

	// One scheduled job as the result channel should report it.
	typedef struct {
		job_rec_t           job;
		logic [COMPL_W-1:0] completion;
		logic [SPAN_W-1:0]  turnaround;
		logic [SPAN_W-1:0]  waiting;
		logic               final_result;
	} sched_result_t;

	// Ready patterns of the result sink.
	typedef enum int unsigned {
		SINK_STEADY,
		SINK_CHOPPY,
		SINK_SLUGGISH
	} sink_mode_t;

	logic clk;
	logic arst_n;

	npps_job_if job_ch ();
	npps_res_if res_ch ();

	nonpreemptive_priority_scheduler_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_ch.sink),
		.result (res_ch.source)
	);

	job_item_t     pending_jobs[$];
	sched_result_t sched_results[$];

	// Jobs of the batch being collected, in arrival order of the transfers.
	job_rec_t    batch_jobs[BATCH_DEPTH];
	int unsigned batch_size;

	int unsigned mismatch_count;
	int unsigned jobs_accepted;
	logic        job_taken;

	// Sender burst/gap state.
	job_item_t   next_item;
	int unsigned burst_left;
	int unsigned gap_left;

	// Sink pattern state.
	sink_mode_t  stall_mode;
	int unsigned phase_left;
	int unsigned hold_left;
	bit          hold_used;

	// ------------------------------------------------------------------------
	// Scheduling model
	// ------------------------------------------------------------------------

	// Sort the closed batch, run it to the end and queue one result per job
	// in sorted order. Clear the batch for the next one.
	function automatic void plan_batch();
		job_rec_t      swap_rec;
		logic [31:0]   done_at[BATCH_DEPTH];
		bit            finished[BATCH_DEPTH];
		logic [31:0]   now;
		logic [31:0]   next_arr;
		logic [31:0]   span;
		bit            found;
		bit            have_next;
		int unsigned   pick;
		int unsigned   done_cnt;
		int unsigned   i;
		int unsigned   j;
		sched_result_t res;

		// Bubble sort keeps equal keys in transfer order.
		for (i = 0; i + 1 < batch_size; i++) begin
			for (j = 0; j + 1 < batch_size - i; j++) begin
				if (batch_jobs[j].arrival > batch_jobs[j+1].arrival ||
					(batch_jobs[j].arrival == batch_jobs[j+1].arrival &&
					 batch_jobs[j].urgency > batch_jobs[j+1].urgency)) begin
					swap_rec = batch_jobs[j];
					batch_jobs[j] = batch_jobs[j+1];
					batch_jobs[j+1] = swap_rec;
				end
			end
		end

		for (i = 0; i < BATCH_DEPTH; i++) begin
			finished[i] = 1'b0;
			done_at[i] = '0;
		end
		now = '0;
		done_cnt = 0;
		while (done_cnt < batch_size) begin
			found = 1'b0;
			have_next = 1'b0;
			pick = 0;
			next_arr = '0;
			for (i = 0; i < batch_size; i++) begin
				if (!finished[i]) begin
					if (32'(batch_jobs[i].arrival) <= now) begin
						// Strictly lower urgency only: earlier sorted job wins a tie.
						if (!found || batch_jobs[i].urgency < batch_jobs[pick].urgency) begin
							found = 1'b1;
							pick = i;
						end
					end else if (!have_next || 32'(batch_jobs[i].arrival) < next_arr) begin
						have_next = 1'b1;
						next_arr = 32'(batch_jobs[i].arrival);
					end
				end
			end
			if (!found) begin
				// Nothing ready: jump over the idle gap.
				now = next_arr;
			end else begin
				now = now + 32'(batch_jobs[pick].burst);
				done_at[pick] = now;
				finished[pick] = 1'b1;
				done_cnt++;
			end
		end

		for (i = 0; i < batch_size; i++) begin
			res.job = batch_jobs[i];
			res.completion = done_at[i][COMPL_W-1:0];
			span = done_at[i] - 32'(batch_jobs[i].arrival);
			res.turnaround = span[SPAN_W-1:0];
			span = span - 32'(batch_jobs[i].burst);
			res.waiting = span[SPAN_W-1:0];
			res.final_result = (i + 1 == batch_size);
			sched_results.push_back(res);
		end
		batch_size = 0;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic add_job(input int unsigned id, input int unsigned arr,
		input int unsigned burst, input int unsigned urg, input bit fin);
		job_item_t item;
		item.job.job_id  = ID_W'(id);
		item.job.arrival = ARR_W'(arr);
		item.job.burst   = BURST_W'(burst);
		item.job.urgency = URG_W'(urg);
		item.final_job   = fin;
		pending_jobs.push_back(item);
	endtask

	// Queue one batch with random content drawn from the given ranges. The last
	// job carries the end mark unless the batch is left to close on a full buffer.
	task automatic add_random_batch(input int unsigned size, input int unsigned arr_max,
		input int unsigned burst_max, input int unsigned urg_max, input bit mark_last);
		int unsigned k;
		for (k = 0; k < size; k++) begin
			add_job($urandom_range(0, 255), $urandom_range(0, arr_max),
				$urandom_range(0, burst_max), $urandom_range(0, urg_max),
				mark_last && (k + 1 == size));
		end
	endtask

	function automatic int unsigned pick_span(input int unsigned narrow, input int unsigned full);
		case ($urandom_range(0, 2))
			0: pick_span = narrow;
			1: pick_span = narrow * 16;
			default: pick_span = full;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Clock, limit
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#(8_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Capture: model every job transfer, check every result transfer
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			job_taken <= 1'b0;
		end else begin
			job_taken <= job_ch.valid && job_ch.ready;

			if (job_ch.valid && job_ch.ready) begin
				batch_jobs[batch_size].job_id  = job_ch.job_id;
				batch_jobs[batch_size].arrival = job_ch.arrival;
				batch_jobs[batch_size].burst   = job_ch.burst;
				batch_jobs[batch_size].urgency = job_ch.urgency;
				batch_size++;
				jobs_accepted++;
				// The end mark or a full buffer closes the batch.
				if (job_ch.final_job || batch_size == BATCH_DEPTH)
					plan_batch();
			end

			if (res_ch.valid && res_ch.ready) begin
				if (sched_results.size() == 0) begin
					$error("result transfer with nothing scheduled: out_job_id %0d",
						res_ch.out_job_id);
					mismatch_count++;
				end else begin
					sched_result_t want;
					want = sched_results.pop_front();
					check_field("out_job_id", 32'(want.job.job_id), 32'(res_ch.out_job_id));
					check_field("out_arrival", 32'(want.job.arrival), 32'(res_ch.out_arrival));
					check_field("out_burst", 32'(want.job.burst), 32'(res_ch.out_burst));
					check_field("out_urgency", 32'(want.job.urgency), 32'(res_ch.out_urgency));
					check_field("completion", 32'(want.completion), 32'(res_ch.completion));
					check_field("turnaround", 32'(want.turnaround), 32'(res_ch.turnaround));
					check_field("waiting", 32'(want.waiting), 32'(res_ch.waiting));
					check_field("final_result", 32'(want.final_result),
						32'(res_ch.final_result));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Job driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n) begin
			job_ch.valid <= 1'b0;
		end else if (!job_ch.valid || job_taken) begin
			// Channel free: either idle, or the offered job just transferred.
			if (gap_left > 0) begin
				gap_left--;
				job_ch.valid <= 1'b0;
			end else if (pending_jobs.size() > 0) begin
				next_item = pending_jobs.pop_front();
				job_ch.job_id    <= next_item.job.job_id;
				job_ch.arrival   <= next_item.job.arrival;
				job_ch.burst     <= next_item.job.burst;
				job_ch.urgency   <= next_item.job.urgency;
				job_ch.final_job <= next_item.final_job;
				job_ch.valid     <= 1'b1;
				if (burst_left <= 1) begin
					// End of burst: pick the next burst and the gap before it;
					// a zero gap keeps long stretches back to back.
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				job_ch.valid <= 1'b0;
			end
		end
		// Otherwise hold the offered job until it transfers.
	end

	// ------------------------------------------------------------------------
	// Result sink: ready pattern of its own, plus one long hold-off
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			// Once well into the run, block the results for a long stretch while
			// the sender keeps offering, so the unit backs up into its input.
			if (!hold_used && res_ch.valid && jobs_accepted >= 40) begin
				hold_left = 400;
				hold_used = 1'b1;
			end
			if (phase_left == 0) begin
				stall_mode = sink_mode_t'($urandom_range(0, 2));
				phase_left = $urandom_range(16, 96);
			end else begin
				phase_left--;
			end

			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					SINK_STEADY:   res_ch.ready <= 1'b1;
					SINK_CHOPPY:   res_ch.ready <= ($urandom_range(0, 1) == 1);
					SINK_SLUGGISH: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default:       res_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: build stimulus, reset, drain, report
	// ------------------------------------------------------------------------

	initial begin
		int unsigned random_jobs;
		int unsigned size;
		int unsigned kind;

		arst_n = 1'b0;
		job_ch.valid     = 1'b0;
		job_ch.job_id    = '0;
		job_ch.arrival   = '0;
		job_ch.burst     = '0;
		job_ch.urgency   = '0;
		job_ch.final_job = 1'b0;
		res_ch.ready     = 1'b0;
		batch_size     = 0;
		mismatch_count = 0;
		jobs_accepted  = 0;
		burst_left     = 0;
		gap_left       = 0;
		stall_mode     = SINK_STEADY;
		phase_left     = 0;
		hold_left      = 0;
		hold_used      = 1'b0;

		// Single job, all fields zero: zero burst completes at time 0.
		add_job(0, 0, 0, 0, 1'b1);
		// Single job, all fields at maximum: idle jump to a late arrival.
		add_job(255, 65535, 65535, 255, 1'b1);
		// Equal arrivals and equal urgencies: sort must stay stable, and the
		// tie goes to the earlier sorted job.
		add_job(10, 5, 3, 3, 1'b0);
		add_job(11, 5, 7, 1, 1'b0);
		add_job(12, 5, 2, 3, 1'b0);
		add_job(13, 5, 4, 1, 1'b1);
		// Non-preemption, urgency picks among waiting jobs, a zero burst and an
		// idle gap before a late job.
		add_job(20, 0, 10, 9, 1'b0);
		add_job(21, 2, 5, 1, 1'b0);
		add_job(22, 3, 4, 0, 1'b0);
		add_job(23, 100, 1, 5, 1'b0);
		add_job(24, 4, 0, 0, 1'b1);
		// Large values: completion well past 16 bits.
		add_job(30, 65535, 65535, 0, 1'b0);
		add_job(31, 65535, 65535, 255, 1'b0);
		add_job(32, 65534, 65535, 128, 1'b1);

		// A full buffer with no end mark closes on its own.
		add_random_batch(BATCH_DEPTH, 300, 20, 3, 1'b0);
		random_jobs = BATCH_DEPTH;

		// Mostly small batches; a few large and full ones.
		while (random_jobs < 220) begin
			kind = $urandom_range(0, 99);
			if (kind < 6)
				size = BATCH_DEPTH;
			else if (kind < 12)
				size = $urandom_range(9, BATCH_DEPTH - 1);
			else
				size = $urandom_range(1, 8);
			add_random_batch(size, pick_span(20, 65535), pick_span(15, 65535),
				pick_span(3, 255), (size < BATCH_DEPTH) || ($urandom_range(0, 1) == 1));
			random_jobs += size;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every job has transferred and every result has come back.
		while (pending_jobs.size() != 0 || job_ch.valid || sched_results.size() != 0)
			@(negedge clk);
		// Let any stray result show up before judging.
		repeat (200) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule : testbench
